// ----- rtl/core/drsup_pkg.sv -----
// drsup_pkg: shared types, constants and helpers for the dual radio link supervisor
// no dependencies; imported by drsup_lane, dual_radio_link_supervisor, drsup_checker and tb_top

package drsup_pkg;

  // link state codes, also the encoding seen on the output port
  typedef enum logic [1:0] {
    LS_FAILED  = 2'd0,
    LS_TX      = 2'd1,
    LS_RX_WAIT = 2'd2,
    LS_RX_RUN  = 2'd3
  } link_state_t;

  // channel mode codes
  localparam logic [1:0] MODE_TX = 2'd1;
  localparam logic [1:0] MODE_RX = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_MODE_A    = 2'd0;
  localparam logic [1:0] REG_MODE_B    = 2'd1;
  localparam logic [1:0] REG_TIMEOUT_A = 2'd2;
  localparam logic [1:0] REG_TIMEOUT_B = 2'd3;

  // input action codes
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_QUEUE = 1'b1;

  // field widths
  localparam int LEN_W   = 6;
  localparam int PHASE_W = 10;
  localparam int CNT_W   = 16;

  // defaults for the top level parameters
  localparam int PAYLOAD_BYTES_DEF = 32;
  localparam int BLINK_PERIOD_DEF  = 1000;

  // reset values of the registers
  localparam logic [1:0]       MODE_A_RST  = MODE_TX;
  localparam logic [1:0]       MODE_B_RST  = MODE_RX;
  localparam logic [CNT_W-1:0] TIMEOUT_RST = CNT_W'(500);

  // led pattern phases
  localparam logic [PHASE_W-1:0] PH_WAIT_LIT_END = PHASE_W'(500);
  localparam logic [PHASE_W-1:0] PH_RUN_ON0      = PHASE_W'(0);
  localparam logic [PHASE_W-1:0] PH_RUN_ON1      = PHASE_W'(130);
  localparam logic [PHASE_W-1:0] PH_RUN_OFF0     = PHASE_W'(30);
  localparam logic [PHASE_W-1:0] PH_RUN_OFF1     = PHASE_W'(160);

  // per-lane control going in
  typedef struct packed {
    logic                   tick;
    logic                   queue;
    logic                   irq;
    logic [LEN_W-1:0]       rx_len;
    logic [PHASE_W-1:0]     phase;
    logic                   mode_we;
    logic [1:0]             mode;
    logic [CNT_W-1:0]       timeout;
  } lane_in_t;

  // per-lane results coming out
  typedef struct packed {
    logic        start_tx;
    logic        forward;
    logic        clear_irq;
    logic        led;
    link_state_t link_state;
    logic        pending;
  } lane_out_t;

  // link state loaded from a mode value; unknown modes mean failed
  function automatic link_state_t state_from_mode(input logic [1:0] m);
    link_state_t s;
    case (m)
      MODE_TX: s = LS_TX;
      MODE_RX: s = LS_RX_WAIT;
      default: s = LS_FAILED;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/core/drsup_lane.sv -----
// drsup_lane: per-channel link control (send, receive, silence timeout, led)
// depends on drsup_pkg

module drsup_lane
  import drsup_pkg::*;
#(
  parameter int          PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
  parameter link_state_t RESET_STATE   = LS_FAILED
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  lane_in_t  ctl,
  output lane_out_t res
);

  link_state_t        link_state, link_state_next;
  logic               pending, pending_next;
  logic               in_flight, in_flight_next;
  logic [CNT_W-1:0]   silence, silence_next;
  logic               led, led_next;
  logic [CNT_W-1:0]   silence_inc;
  logic               start_tx, forward, clear_irq;

  assign silence_inc = (silence != {CNT_W{1'b1}}) ? silence + CNT_W'(1) : silence;

  // next state of the lane
  always_comb begin
    link_state_next = link_state;
    pending_next    = pending;
    in_flight_next  = in_flight;
    silence_next    = silence;
    led_next        = led;
    start_tx        = 1'b0;
    forward         = 1'b0;
    clear_irq       = 1'b0;
    if (ctl.queue) begin
      pending_next = 1'b1;
    end
    if (ctl.tick) begin
      // led from the state held before this tick
      case (link_state)
        LS_TX:      led_next = 1'b1;
        LS_RX_WAIT: led_next = (ctl.phase <= PH_WAIT_LIT_END);
        LS_RX_RUN: begin
          if (ctl.phase == PH_RUN_ON0 || ctl.phase == PH_RUN_ON1) led_next = 1'b1;
          if (ctl.phase == PH_RUN_OFF0 || ctl.phase == PH_RUN_OFF1) led_next = 1'b0;
        end
        default:    led_next = 1'b0;
      endcase
      case (link_state)
        LS_TX: begin
          if (pending && !in_flight) begin
            pending_next   = 1'b0;
            in_flight_next = 1'b1;
            start_tx       = 1'b1;
          end else if (in_flight && ctl.irq) begin
            in_flight_next = 1'b0;
          end
        end
        LS_RX_WAIT, LS_RX_RUN: begin
          if (ctl.irq) begin
            if (ctl.rx_len == LEN_W'(PAYLOAD_BYTES)) begin
              link_state_next = LS_RX_RUN;
              forward         = 1'b1;
            end
            silence_next = '0;
          end else if (silence_inc >= ctl.timeout) begin
            clear_irq       = 1'b1;
            link_state_next = LS_RX_WAIT;
            silence_next    = '0;
          end else begin
            silence_next = silence_inc;
          end
        end
        default: ;
      endcase
    end
    // mode write reloads the link, keeps a pending packet
    if (ctl.mode_we) begin
      link_state_next = state_from_mode(ctl.mode);
      in_flight_next  = 1'b0;
      silence_next    = '0;
    end
  end

  // lane registers
  always_ff @(posedge clk) begin
    if (rst) begin
      link_state <= RESET_STATE;
      pending    <= 1'b0;
      in_flight  <= 1'b0;
      silence    <= '0;
      led        <= 1'b0;
    end else if (step || ctl.mode_we) begin
      link_state <= link_state_next;
      pending    <= pending_next;
      in_flight  <= in_flight_next;
      silence    <= silence_next;
      led        <= led_next;
    end
  end

  // results as seen after this request; pending is the value held before it
  assign res.start_tx   = start_tx;
  assign res.forward    = forward;
  assign res.clear_irq  = clear_irq;
  assign res.led        = led_next;
  assign res.link_state = link_state_next;
  assign res.pending    = pending;

endmodule

// ----- rtl/core/dual_radio_link_supervisor.sv -----
// dual_radio_link_supervisor: top level, two channel lanes, blink phase, result merge
// depends on drsup_pkg and drsup_lane
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tuser: action, channel
//                                                    tdata: irq_a, irq_b, rx_length_a/b
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata: status, strobes, leds, states
//  cfg       in         cfg_valid/cfg_ready          cfg_index, cfg_data
//
//  one request per cycle while the output is not stalled: both lanes update in the accept
//  cycle, and the merged result is registered in the output register
//  the single output register sets the rate; a request is taken when that register is
//  empty or when the held result is being taken in the same cycle
//  reset (rst, synchronous) loads the link states from the default modes
//  configuration writes are always ready

module dual_radio_link_supervisor
  import drsup_pkg::*;
#(
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
  parameter int BLINK_PERIOD  = BLINK_PERIOD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // irq_a, irq_b, rx_length_a[5:0], rx_length_b[5:0], zeros
  input  logic [1:0]  s_axis_tuser,  // action, channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // queue_status, start_tx_a, start_tx_b, forward_a,
                                     // forward_b, clear_irq_a, clear_irq_b, led_a, led_b,
                                     // link_state_a[1:0], link_state_b[1:0], zeros
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic               accept, cfg_we;
  logic               action, chan;
  logic [PHASE_W-1:0] phase, phase_inc, phase_next;
  logic [CNT_W-1:0]   timeout_a, timeout_b;
  lane_in_t           ctl_a, ctl_b;
  lane_out_t          res_a, res_b;
  logic               queue_status;
  logic               out_valid;
  logic [15:0]        out_data;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign cfg_ready     = 1'b1;
  assign cfg_we        = cfg_valid && cfg_ready;
  assign action        = s_axis_tuser[0];
  assign chan          = s_axis_tuser[1];

  // timeout registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_a <= TIMEOUT_RST;
      timeout_b <= TIMEOUT_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_TIMEOUT_A) timeout_a <= cfg_data;
      if (cfg_index == REG_TIMEOUT_B) timeout_b <= cfg_data;
    end
  end

  // blink phase advance with wrap at the period
  assign phase_inc  = phase + PHASE_W'(1);
  assign phase_next = (phase_inc >= PHASE_W'(BLINK_PERIOD)) ? '0 : phase_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (accept && action == ACT_TICK) begin
      phase <= phase_next;
    end
  end

  // lane controls
  always_comb begin
    ctl_a.tick    = accept && action == ACT_TICK;
    ctl_a.queue   = accept && action == ACT_QUEUE && !chan;
    ctl_a.irq     = s_axis_tdata[0];
    ctl_a.rx_len  = s_axis_tdata[7:2];
    ctl_a.phase   = phase_next;
    ctl_a.mode_we = cfg_we && cfg_index == REG_MODE_A;
    ctl_a.mode    = cfg_data[1:0];
    ctl_a.timeout = timeout_a;
    ctl_b.tick    = accept && action == ACT_TICK;
    ctl_b.queue   = accept && action == ACT_QUEUE && chan;
    ctl_b.irq     = s_axis_tdata[1];
    ctl_b.rx_len  = s_axis_tdata[13:8];
    ctl_b.phase   = phase_next;
    ctl_b.mode_we = cfg_we && cfg_index == REG_MODE_B;
    ctl_b.mode    = cfg_data[1:0];
    ctl_b.timeout = timeout_b;
  end

  drsup_lane #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .RESET_STATE   (state_from_mode(MODE_A_RST))
  ) u_lane_a (
    .clk  (clk),
    .rst  (rst),
    .step (accept),
    .ctl  (ctl_a),
    .res  (res_a)
  );

  drsup_lane #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .RESET_STATE   (state_from_mode(MODE_B_RST))
  ) u_lane_b (
    .clk  (clk),
    .rst  (rst),
    .step (accept),
    .ctl  (ctl_b),
    .res  (res_b)
  );

  // merge: busy answer from the addressed lane
  assign queue_status = (action == ACT_QUEUE) && (chan ? res_b.pending : res_a.pending);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= {3'b000, res_b.link_state, res_a.link_state, res_b.led, res_a.led,
                   res_b.clear_irq, res_a.clear_irq, res_b.forward, res_a.forward,
                   res_b.start_tx, res_a.start_tx, queue_status};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

// ----- rtl/core/drsup_checker.sv -----
// drsup_checker: port-level assertions for dual_radio_link_supervisor, and its bind
// depends on drsup_pkg

module drsup_checker
  import drsup_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [1:0]  cfg_index,
  input logic [15:0] cfg_data
);

  // a held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  // every accepted request shows a result next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted request produced no result");

  // a rejected queue request carries no tick strobes
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[6:1] == 6'b0)
    else $error("strobes on a queue answer");

  // a timeout leaves channel A waiting
  a_clr_a: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[5] |-> m_axis_tdata[10:9] == LS_RX_WAIT)
    else $error("clear on A without waiting state");

  // a forward leaves channel B running
  a_fwd_b: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[12:11] == LS_RX_RUN)
    else $error("forward on B without running state");

endmodule

bind dual_radio_link_supervisor drsup_checker u_drsup_checker (.*);

// ----- tb/tb_top.sv -----
// tb_top: self-checking testbench for dual_radio_link_supervisor
// depends on drsup_pkg and the rtl top level; predicts each status word and checks it field by field
`timescale 1ns / 1ps

module tb_top
  import drsup_pkg::*;
();

  // off codes that the package leaves unnamed
  localparam logic [1:0] MODE_OFF = 2'd0;
  localparam logic [1:0] MODE_ODD = 2'd3;
  localparam logic       CH_A     = 1'b0;
  localparam logic       CH_B     = 1'b1;
  localparam int         CYCLE_LIMIT = 400000;

  // status word as it sits on m_axis_tdata, lowest field last
  typedef struct packed {
    logic [2:0]  pad;
    link_state_t link_b;
    link_state_t link_a;
    logic        led_b;
    logic        led_a;
    logic        clear_irq_b;
    logic        clear_irq_a;
    logic        forward_b;
    logic        forward_a;
    logic        start_tx_b;
    logic        start_tx_a;
    logic        queue_status;
  } report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // irq_a, irq_b, rx_length_a[5:0], rx_length_b[5:0], zeros
  logic [1:0]  s_axis_tuser = '0;  // action, channel
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;       // queue_status, start_tx_a/b, forward_a/b, clear_irq_a/b,
                                   // led_a, led_b, link_state_a[1:0], link_state_b[1:0], zeros
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // supervisor image kept by the testbench
  logic [1:0]         chan_mode   [2];
  logic [CNT_W-1:0]   rx_timeout  [2];
  logic [PHASE_W-1:0] blink_count;
  link_state_t        chan_state  [2];
  logic               pkt_queued  [2];
  logic               send_busy   [2];
  logic [CNT_W-1:0]   quiet_ticks [2];
  logic               led_on      [2];

  report_t due_reports[$];
  report_t want_rep;
  report_t got_rep;
  int      mismatches = 0;
  int      cycle_count = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;

  dual_radio_link_supervisor DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic link_state_t mode_to_state(input logic [1:0] m);
    if (m == MODE_TX) return LS_TX;
    if (m == MODE_RX) return LS_RX_WAIT;
    return LS_FAILED;
  endfunction

  // next status word of the supervisor for one request; updates the image
  function automatic report_t supervise(input logic [1:0] user, input logic [15:0] data);
    report_t    r;
    logic [1:0] irq;
    logic [5:0] len [2];
    logic [1:0] start;
    logic [1:0] fwd;
    logic [1:0] clr;
    logic       ch;
    int         c;
    r = '0;
    start = '0;
    fwd = '0;
    clr = '0;
    irq = data[1:0];
    len[0] = data[7:2];
    len[1] = data[13:8];
    ch = user[1];
    if (user[0] == ACT_QUEUE) begin
      if (pkt_queued[ch]) r.queue_status = 1'b1;
      else pkt_queued[ch] = 1'b1;
    end else begin
      blink_count = blink_count + 1'b1;
      if (blink_count >= BLINK_PERIOD_DEF) blink_count = '0;
      // leds follow the link state from before this tick
      for (c = 0; c < 2; c++) begin
        case (chan_state[c])
          LS_TX: led_on[c] = 1'b1;
          LS_RX_WAIT: led_on[c] = (blink_count <= PH_WAIT_LIT_END);
          LS_RX_RUN: begin
            if (blink_count == PH_RUN_ON0 || blink_count == PH_RUN_ON1) led_on[c] = 1'b1;
            if (blink_count == PH_RUN_OFF0 || blink_count == PH_RUN_OFF1) led_on[c] = 1'b0;
          end
          default: led_on[c] = 1'b0;
        endcase
      end
      // per channel link update
      for (c = 0; c < 2; c++) begin
        case (chan_state[c])
          LS_TX: begin
            if (pkt_queued[c] && !send_busy[c]) begin
              pkt_queued[c] = 1'b0;
              send_busy[c] = 1'b1;
              start[c] = 1'b1;
            end else if (send_busy[c] && irq[c]) begin
              send_busy[c] = 1'b0;
            end
          end
          LS_RX_WAIT, LS_RX_RUN: begin
            if (irq[c]) begin
              if (len[c] == PAYLOAD_BYTES_DEF) begin
                chan_state[c] = LS_RX_RUN;
                fwd[c] = 1'b1;
              end
              quiet_ticks[c] = '0;
            end else begin
              if (quiet_ticks[c] != '1) quiet_ticks[c] = quiet_ticks[c] + 1'b1;
              if (quiet_ticks[c] >= rx_timeout[c]) begin
                clr[c] = 1'b1;
                chan_state[c] = LS_RX_WAIT;
                quiet_ticks[c] = '0;
              end
            end
          end
          default: ;
        endcase
      end
    end
    r.start_tx_a = start[0];
    r.start_tx_b = start[1];
    r.forward_a = fwd[0];
    r.forward_b = fwd[1];
    r.clear_irq_a = clr[0];
    r.clear_irq_b = clr[1];
    r.led_a = led_on[0];
    r.led_b = led_on[1];
    r.link_a = chan_state[0];
    r.link_b = chan_state[1];
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // status word checker
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (due_reports.size() == 0) begin
        $display("%0t: unexpected status word expected none actual %h", $time, m_axis_tdata);
        mismatches++;
      end else begin
        want_rep = due_reports.pop_front();
        got_rep = report_t'(m_axis_tdata);
        check_field("queue_status", want_rep.queue_status, got_rep.queue_status);
        check_field("start_tx_a", want_rep.start_tx_a, got_rep.start_tx_a);
        check_field("start_tx_b", want_rep.start_tx_b, got_rep.start_tx_b);
        check_field("forward_a", want_rep.forward_a, got_rep.forward_a);
        check_field("forward_b", want_rep.forward_b, got_rep.forward_b);
        check_field("clear_irq_a", want_rep.clear_irq_a, got_rep.clear_irq_a);
        check_field("clear_irq_b", want_rep.clear_irq_b, got_rep.clear_irq_b);
        check_field("led_a", want_rep.led_a, got_rep.led_a);
        check_field("led_b", want_rep.led_b, got_rep.led_b);
        check_field("link_state_a", want_rep.link_a, got_rep.link_a);
        check_field("link_state_b", want_rep.link_b, got_rep.link_b);
      end
    end
  end

  function automatic logic [15:0] tick_word(input logic ia, input logic ib,
                                            input logic [5:0] la, input logic [5:0] lb);
    return {2'b00, lb, la, ib, ia};
  endfunction

  function automatic logic [5:0] rand_len();
    return ($urandom_range(99) < 60) ? 6'd32 : 6'($urandom_range(32));
  endfunction

  // one request on the slave side; entered and left at a falling edge
  task automatic send_request(input logic [1:0] user, input logic [15:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= user;
    s_axis_tdata <= data;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    due_reports.push_back(supervise(user, data));
    @(negedge clk);
  endtask

  task automatic send_tick(input logic ia, input logic ib,
                           input logic [5:0] la, input logic [5:0] lb);
    send_request({1'($urandom_range(1)), ACT_TICK}, tick_word(ia, ib, la, lb));
  endtask

  task automatic send_queue(input logic ch);
    send_request({ch, ACT_QUEUE}, {2'b00, 14'($urandom)});
  endtask

  // hold the sender until every status word is back
  task automatic wait_reports_done();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (due_reports.size() != 0);
  endtask

  // register write while the block is idle
  task automatic write_register(input logic [1:0] index, input logic [15:0] value);
    int c;
    wait_reports_done();
    repeat (2) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (index == REG_MODE_A || index == REG_MODE_B) begin
      c = (index == REG_MODE_A) ? 0 : 1;
      chan_mode[c] = value[1:0];
      chan_state[c] = mode_to_state(value[1:0]);
      send_busy[c] = 1'b0;
      quiet_ticks[c] = '0;
    end else begin
      c = (index == REG_TIMEOUT_A) ? 0 : 1;
      rx_timeout[c] = value;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // queue, reject while pending, start, wait for the send to finish
  task automatic test_transmit_path();
    send_queue(CH_A);
    send_queue(CH_A);
    send_tick(1'b0, 1'b0, 6'd0, 6'd0);
    send_queue(CH_A);
    send_tick(1'b0, 1'b0, 6'd5, 6'd0);
    send_tick(1'b1, 1'b0, 6'd32, 6'd0);
    send_tick(1'b0, 1'b0, 6'd0, 6'd0);
  endtask

  // full and short packets on the receive channel
  task automatic test_receive_path();
    send_tick(1'b0, 1'b1, 6'd0, 6'd32);
    send_tick(1'b0, 1'b1, 6'd0, 6'd31);
    send_tick(1'b0, 1'b1, 6'd0, 6'd0);
    send_tick(1'b1, 1'b1, 6'd32, 6'd32);
  endtask

  // shortest timeouts, zero timeout, and a timeout lowered under the count
  task automatic test_timeouts();
    write_register(REG_TIMEOUT_B, 16'd1);
    send_tick(1'b0, 1'b0, 6'd0, 6'd0);
    write_register(REG_TIMEOUT_B, 16'd0);
    send_tick(1'b0, 1'b0, 6'd0, 6'd32);
    write_register(REG_TIMEOUT_B, 16'd6);
    repeat (3) send_tick(1'b0, 1'b0, 6'd0, 6'd0);
    write_register(REG_TIMEOUT_B, 16'd2);
    send_tick(1'b0, 1'b0, 6'd0, 6'd0);
    write_register(REG_TIMEOUT_B, 16'hFFFF);
    write_register(REG_TIMEOUT_A, 16'd0);
  endtask

  // mode reloads, odd mode, pending packet kept across a mode change
  task automatic test_mode_changes();
    send_queue(CH_B);
    write_register(REG_MODE_B, {14'd0, MODE_TX});
    send_tick(1'b0, 1'b0, 6'd0, 6'd0);
    write_register(REG_MODE_A, {14'h3FFF, MODE_ODD});
    send_tick(1'b1, 1'b0, 6'd32, 6'd0);
    send_queue(CH_A);
    write_register(REG_MODE_A, {14'd0, MODE_OFF});
    write_register(REG_MODE_A, {14'd0, MODE_RX});
    write_register(REG_TIMEOUT_A, 16'd1);
    send_tick(1'b1, 1'b0, 6'd32, 6'd0);
    send_tick(1'b0, 1'b0, 6'd0, 6'd0);
    write_register(REG_MODE_B, {14'd0, MODE_RX});
  endtask

  // new random modes and timeouts for both channels
  task automatic shuffle_settings();
    int          c;
    int          pick;
    logic [1:0]  m;
    logic [15:0] t;
    for (c = 0; c < 2; c++) begin
      pick = $urandom_range(99);
      if (pick < 40) m = MODE_TX;
      else if (pick < 80) m = MODE_RX;
      else if (pick < 90) m = MODE_OFF;
      else m = MODE_ODD;
      pick = $urandom_range(99);
      if (pick < 80) t = 16'($urandom_range(40, 1));
      else if (pick < 85) t = 16'd0;
      else if (pick < 90) t = 16'd1;
      else if (pick < 95) t = 16'hFFFF;
      else t = 16'($urandom_range(65535, 41));
      write_register(c ? REG_MODE_B : REG_MODE_A, {14'($urandom), m});
      write_register(c ? REG_TIMEOUT_B : REG_TIMEOUT_A, t);
    end
  endtask

  // mostly ticks with random interrupts, some queue requests, rare pauses
  task automatic run_random_chunk(input int n);
    repeat (n) begin
      if ($urandom_range(99) < 2) wait_reports_done();
      if ($urandom_range(99) < 15) send_queue(1'($urandom_range(1)));
      else send_tick($urandom_range(99) < 35, $urandom_range(99) < 35, rand_len(), rand_len());
    end
  endtask

  task automatic test_random_traffic();
    int phase_n;
    for (phase_n = 0; phase_n < 3; phase_n++) begin
      case (phase_n)
        0: begin
          send_idle_pct = 21;
          recv_idle_pct = 82;
        end
        1: begin
          send_idle_pct = 82;
          recv_idle_pct = 21;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (4) begin
        shuffle_settings();
        run_random_chunk(104);
      end
    end
  endtask

  // main sequence
  initial begin
    chan_mode[0] = MODE_A_RST;
    chan_mode[1] = MODE_B_RST;
    for (int c = 0; c < 2; c++) begin
      rx_timeout[c] = TIMEOUT_RST;
      chan_state[c] = mode_to_state(chan_mode[c]);
      pkt_queued[c] = 1'b0;
      send_busy[c] = 1'b0;
      quiet_ticks[c] = '0;
      led_on[c] = 1'b0;
    end
    blink_count = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_transmit_path();
    test_receive_path();
    test_timeouts();
    test_mode_changes();
    test_random_traffic();
    wait_reports_done();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && due_reports.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
